// ===== sv/hpq_pkg.sv =====
// shared types, constants and helpers for the binary heap priority queue
// no dependencies
package hpq_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 16;
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);
  localparam int ADDR_BITS  = $clog2(CAPACITY);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;

  typedef struct packed {
    key_t   key;
    value_t value;
  } entry_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } hpq_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_CMP,
    ST_POP_LAST,
    ST_POP_LEFT_RD,
    ST_POP_LEFT,
    ST_POP_RIGHT,
    ST_POP_CMP,
    ST_EMIT
  } hpq_state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_PUSH_BEGIN,
    CMD_PUSH_READ,
    CMD_PUSH_MOVE,
    CMD_PUSH_PLACE,
    CMD_POP_BEGIN,
    CMD_POP_LAST,
    CMD_POP_READ_LEFT,
    CMD_POP_LEFT,
    CMD_POP_RIGHT,
    CMD_POP_MOVE,
    CMD_POP_PLACE,
    CMD_REFUSE_FULL,
    CMD_REFUSE_EMPTY,
    CMD_EMIT
  } hpq_cmd_e;

  typedef struct packed {
    logic full;
    logic empty;
    logic has_parent;
    logic push_move;
    logic has_child;
    logic has_right;
    logic pop_move;
    logic out_free;
  } hpq_stat_t;

  // true when key a belongs strictly below key b
  function automatic logic sinks_below(input logic max_first, input key_t a, input key_t b);
    return max_first ? (a < b) : (a > b);
  endfunction

  // heap position (one-based) to memory address
  function automatic addr_t pos_addr(input cnt_t pos);
    cnt_t a;
    a = pos - cnt_t'(1);
    return a[ADDR_BITS-1:0];
  endfunction

endpackage

// ===== sv/hpq_ctrl.sv =====
// sequencer for push sift-up and pop sift-down
// depends on hpq_pkg
module hpq_ctrl
  import hpq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       opcode_i,
  input  hpq_stat_t  stat_i,
  output logic       in_stall_o,
  output hpq_cmd_e   cmd_o
);

  hpq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NONE;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_PUSH) begin
            if (stat_i.full) begin
              cmd_o   = CMD_REFUSE_FULL;
              state_d = ST_EMIT;
            end else begin
              cmd_o   = CMD_PUSH_BEGIN;
              state_d = ST_PUSH_RD;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o   = CMD_REFUSE_EMPTY;
              state_d = ST_EMIT;
            end else begin
              cmd_o   = CMD_POP_BEGIN;
              state_d = ST_POP_LAST;
            end
          end
        end
      end
      ST_PUSH_RD: begin
        if (stat_i.has_parent) begin
          cmd_o   = CMD_PUSH_READ;
          state_d = ST_PUSH_CMP;
        end else begin
          cmd_o   = CMD_PUSH_PLACE;
          state_d = ST_EMIT;
        end
      end
      ST_PUSH_CMP: begin
        if (stat_i.push_move) begin
          cmd_o   = CMD_PUSH_MOVE;
          state_d = ST_PUSH_RD;
        end else begin
          cmd_o   = CMD_PUSH_PLACE;
          state_d = ST_EMIT;
        end
      end
      ST_POP_LAST: begin
        cmd_o   = CMD_POP_LAST;
        state_d = ST_POP_LEFT_RD;
      end
      ST_POP_LEFT_RD: begin
        if (stat_i.has_child) begin
          cmd_o   = CMD_POP_READ_LEFT;
          state_d = ST_POP_LEFT;
        end else begin
          cmd_o   = CMD_POP_PLACE;
          state_d = ST_EMIT;
        end
      end
      ST_POP_LEFT: begin
        cmd_o   = CMD_POP_LEFT;
        state_d = stat_i.has_right ? ST_POP_RIGHT : ST_POP_CMP;
      end
      ST_POP_RIGHT: begin
        cmd_o   = CMD_POP_RIGHT;
        state_d = ST_POP_CMP;
      end
      ST_POP_CMP: begin
        if (stat_i.pop_move) begin
          cmd_o   = CMD_POP_MOVE;
          state_d = ST_POP_LEFT_RD;
        end else begin
          cmd_o   = CMD_POP_PLACE;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o   = CMD_EMIT;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/hpq_datapath.sv =====
// heap storage, index registers, compare logic and result register
// depends on hpq_pkg
module hpq_datapath
  import hpq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  key_t       entry_key_i,
  input  value_t     entry_value_i,
  input  hpq_cmd_e   cmd_i,
  output hpq_stat_t  stat_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output key_t       removed_key_o,
  output value_t     removed_value_o,
  output key_t       top_key_o,
  output value_t     top_value_o,
  output cnt_t       count_o,
  output logic       is_empty_o
);

  entry_t mem [CAPACITY];

  logic        order_q;
  cnt_t        count_q;
  logic        out_valid_q;
  cnt_t        pos_q;
  cnt_t        cpos_q;
  entry_t      mov_q;
  entry_t      ck_q;
  entry_t      rd_q;
  entry_t      top_q;
  entry_t      rem_q;
  hpq_status_e status_q;

  logic        rd_en;
  addr_t       rd_addr;
  logic        wr_en;
  addr_t       wr_addr;
  entry_t      wr_data;

  logic [CNT_BITS:0] left_pos;
  cnt_t              par_pos;
  logic              out_take;
  logic              emit;

  assign left_pos = {pos_q, 1'b0};
  assign par_pos  = pos_q >> 1;
  assign out_take = out_valid_q && !out_stall_i;
  assign emit     = (cmd_i == CMD_EMIT);

  assign stat_o.full       = (count_q == cnt_t'(CAPACITY));
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.has_parent = (pos_q > cnt_t'(1));
  assign stat_o.push_move  = sinks_below(order_q, rd_q.key, mov_q.key);
  assign stat_o.has_child  = (left_pos <= {1'b0, count_q});
  assign stat_o.has_right  = (cpos_q != count_q);
  assign stat_o.pop_move   = sinks_below(order_q, mov_q.key, ck_q.key);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos_addr(pos_q);
    wr_data = mov_q;
    case (cmd_i)
      CMD_PUSH_READ: begin
        rd_en   = 1'b1;
        rd_addr = pos_addr(par_pos);
      end
      CMD_PUSH_MOVE: begin
        wr_en   = 1'b1;
        wr_data = rd_q;
      end
      CMD_PUSH_PLACE, CMD_POP_PLACE: begin
        wr_en   = 1'b1;
        wr_data = mov_q;
      end
      CMD_POP_BEGIN: begin
        rd_en   = 1'b1;
        rd_addr = pos_addr(count_q);
      end
      CMD_POP_READ_LEFT: begin
        rd_en   = 1'b1;
        rd_addr = pos_addr(left_pos[CNT_BITS-1:0]);
      end
      CMD_POP_LEFT: begin
        // right sibling sits at position cpos_q + 1
        rd_en   = 1'b1;
        rd_addr = cpos_q[ADDR_BITS-1:0];
      end
      CMD_POP_MOVE: begin
        wr_en   = 1'b1;
        wr_data = ck_q;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    // root mirror
    if (wr_en && wr_addr == '0) begin
      top_q <= wr_data;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      if (cmd_i == CMD_PUSH_BEGIN) begin
        count_q <= count_q + cnt_t'(1);
      end else if (cmd_i == CMD_POP_BEGIN) begin
        count_q <= count_q - cnt_t'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_PUSH_BEGIN: begin
        mov_q    <= '{key: entry_key_i, value: entry_value_i};
        pos_q    <= count_q + cnt_t'(1);
        rem_q    <= '0;
        status_q <= STATUS_DONE;
      end
      CMD_PUSH_MOVE: begin
        pos_q <= par_pos;
      end
      CMD_POP_BEGIN: begin
        rem_q    <= top_q;
        pos_q    <= cnt_t'(1);
        status_q <= STATUS_DONE;
      end
      CMD_POP_LAST: begin
        mov_q <= rd_q;
      end
      CMD_POP_READ_LEFT: begin
        cpos_q <= left_pos[CNT_BITS-1:0];
      end
      CMD_POP_LEFT: begin
        ck_q <= rd_q;
      end
      CMD_POP_RIGHT: begin
        // left child wins ties
        if (sinks_below(order_q, ck_q.key, rd_q.key)) begin
          ck_q   <= rd_q;
          cpos_q <= cpos_q + cnt_t'(1);
        end
      end
      CMD_POP_MOVE: begin
        pos_q <= cpos_q;
      end
      CMD_REFUSE_FULL: begin
        rem_q    <= '0;
        status_q <= STATUS_FULL;
      end
      CMD_REFUSE_EMPTY: begin
        rem_q    <= '0;
        status_q <= STATUS_EMPTY;
      end
      default: begin
        pos_q <= pos_q;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_o        <= status_q;
      removed_key_o   <= rem_q.key;
      removed_value_o <= rem_q.value;
      top_key_o       <= (count_q == '0) ? '0 : top_q.key;
      top_value_o     <= (count_q == '0) ? '0 : top_q.value;
      count_o         <= count_q;
      is_empty_o      <= (count_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/binary_heap_priority_queue.sv =====
// binary heap priority queue, top level: sequencer plus heap datapath
// depends on hpq_pkg, hpq_ctrl, hpq_datapath
//
// usage
//   each request on the input channel is a push (opcode 0, key and value)
//   or a pop (opcode 1); every request gives exactly one result carrying
//   the status, the removed entry, the new top entry and the count
//   order_max_first is written through cfg_we_i / cfg_wdata_i; the user
//   writes it only while idle, which the block itself does not enforce
//   a push reads and compares one parent entry per level climbed; a pop
//   reads the left child, then the right child when there is one, and
//   compares once per level descended
//   the heap memory has a single read port with a registered read, so
//   entries are read one at a time
//   one request is in work at a time; in_stall_o is high from acceptance
//   until the result is loaded into the output register
//   refused requests (push when full, pop when empty) skip to the result
//   when the receiver stalls, the result holds and the block finishes its
//   next request only up to the point of loading the result register
//   reset empties the heap, clears the order bit to min-first and drops any
//   pending result; no clearing pass is needed
module binary_heap_priority_queue
  import hpq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       opcode_i,
  input  key_t       entry_key_i,
  input  value_t     entry_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output key_t       removed_key_o,
  output value_t     removed_value_o,
  output key_t       top_key_o,
  output value_t     top_value_o,
  output cnt_t       count_o,
  output logic       is_empty_o
);

  hpq_cmd_e  cmd;
  hpq_stat_t stat;

  hpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  hpq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .entry_key_i     (entry_key_i),
    .entry_value_i   (entry_value_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .removed_key_o   (removed_key_o),
    .removed_value_o (removed_value_o),
    .top_key_o       (top_key_o),
    .top_value_o     (top_value_o),
    .count_o         (count_o),
    .is_empty_o      (is_empty_o)
  );

  // busy after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after accepting a request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= cnt_t'(CAPACITY)))
    else $error("count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (count_o == '0)))
    else $error("empty flag disagrees with count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_DONE) |->
      (removed_key_o == '0 && removed_value_o == '0))
    else $error("refused request reports a removed entry");

endmodule
